// ===== rtl/tehq_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer event heap queue package
// Shared types, codes and constants of the timer event heap queue.
// ----------------------------------------------------------------------------
package tehq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int TASK_W        = 4;
    localparam int TIME_W        = 32;
    localparam int NTASKS        = 16;
    localparam int POPS_W        = 6;

    localparam logic [POPS_W-1:0] POP_LIMIT = 6'd63;

    localparam logic [1:0] KIND_WAKE     = 2'd0;
    localparam logic [1:0] KIND_DEADLINE = 2'd1;
    localparam logic [1:0] KIND_CLOSE    = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_LIMIT = 2'd2;

    typedef enum logic [1:0] {
        OP_INS_WAKE = 2'd0,
        OP_INS_DL   = 2'd1,
        OP_REMOVE   = 2'd2,
        OP_ADVANCE  = 2'd3
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [TASK_W-1:0] task_id;
        logic [TIME_W-1:0] time_value;
        logic [TIME_W-1:0] period;
    } t_cmd;

    typedef struct packed {
        logic              deadline;
        logic [TASK_W-1:0] task_id;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_WR,
        ST_POP1,
        ST_POP2,
        ST_SD0,
        ST_SD1,
        ST_SD2,
        ST_SDM,
        ST_SDW,
        ST_RM_RD,
        ST_RM_CK,
        ST_RM_UP,
        ST_RM_MV,
        ST_A_TOP,
        ST_A_CK,
        ST_A_FIRE,
        ST_CLOSE
    } t_state;

endpackage

// ===== rtl/tehq_front.sv =====
// ----------------------------------------------------------------------------
// Timer event heap queue front end
// Accepts input transfers, decodes the function and queues the commands.
// ----------------------------------------------------------------------------
module tehq_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_func,
    input  logic [tehq_pkg::TASK_W-1:0] i_task_id,
    input  logic [tehq_pkg::TIME_W-1:0] i_time_value,
    input  logic [tehq_pkg::TIME_W-1:0] i_period,
    output logic                       o_cmd_valid,
    output tehq_pkg::t_cmd             o_cmd,
    input  logic                       i_cmd_pop
);
    import tehq_pkg::*;

    t_cmd       r_q [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_fill;
    t_cmd       w_cmd;
    t_op        w_op;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        unique case (i_func)
            2'd0:    w_op = OP_INS_WAKE;
            2'd1:    w_op = OP_INS_DL;
            2'd2:    w_op = OP_REMOVE;
            default: w_op = OP_ADVANCE;
        endcase
    end

    assign w_cmd  = '{op: w_op, task_id: i_task_id, time_value: i_time_value,
                      period: i_period};
    assign o_stall     = (r_fill == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign w_pop       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (w_pop) begin
                r_rptr <= !r_rptr;
            end
            r_fill <= r_fill + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

// ===== rtl/tehq_back.sv =====
// ----------------------------------------------------------------------------
// Timer event heap queue back end
// Runs heap insert, remove and advance on a single-port event memory.
// ----------------------------------------------------------------------------
module tehq_back #(
    parameter int DEPTH = tehq_pkg::DEPTH_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    input  tehq_pkg::t_cmd              i_cmd,
    output logic                        o_cmd_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_kind,
    output logic [tehq_pkg::TASK_W-1:0] o_fired_task,
    output logic [1:0]                  o_status,
    output logic                        o_any_woken,
    output logic                        o_last,
    output logic [$clog2(DEPTH)-1:0]    o_count
);
    import tehq_pkg::*;

    localparam int IW = $clog2(DEPTH);

    t_entry              r_mem [DEPTH];
    t_entry              r_rdata;
    logic [TIME_W-1:0]   r_period [NTASKS];

    t_state              r_state, n_state;
    logic [IW-1:0]       r_cnt, n_cnt;
    logic [IW-1:0]       r_i, n_i;
    logic [IW-1:0]       r_j, n_j;
    logic [IW-1:0]       r_bi, n_bi;
    t_entry              r_new, n_new;
    t_entry              r_last, n_last;
    t_entry              r_top, n_top;
    t_entry              r_best, n_best;
    logic [TIME_W-1:0]   r_tnow, n_tnow;
    logic [POPS_W-1:0]   r_pops, n_pops;
    logic                r_woken, n_woken;
    logic [1:0]          r_status, n_status;
    logic                r_adv, n_adv;

    logic                r_ovalid, n_ovalid;
    logic [1:0]          r_okind, n_okind;
    logic [TASK_W-1:0]   r_otask, n_otask;
    logic [1:0]          r_ostatus, n_ostatus;
    logic                r_owoken, n_owoken;
    logic                r_olast, n_olast;

    logic                w_rd_en, w_wr_en, w_per_we;
    logic [IW-1:0]       w_rd_addr, w_wr_addr;
    t_entry              w_wr_data;
    logic [IW-1:0]       w_pi, w_pj;
    logic [IW+1:0]       w_l, w_r, w_cnt_x;
    logic                w_l_ok, w_r_ok;
    logic                w_full, w_free, w_due;
    logic [TIME_W:0]     w_sum;
    logic [TIME_W-1:0]   w_next_stamp;

    assign w_pi    = IW'((r_i - 1'b1) >> 1);
    assign w_pj    = IW'((r_j - 1'b1) >> 1);
    assign w_l     = {1'b0, r_i, 1'b1};
    assign w_r     = w_l + 1'b1;
    assign w_cnt_x = {2'b00, r_cnt};
    assign w_l_ok  = w_l < w_cnt_x;
    assign w_r_ok  = w_r < w_cnt_x;
    assign w_full  = (r_cnt == IW'(DEPTH - 1));
    assign w_free  = !r_ovalid || !i_stall;
    assign w_due   = r_rdata.stamp <= r_tnow;
    assign w_sum   = {1'b0, r_top.stamp} + {1'b0, r_period[r_top.task_id]};
    assign w_next_stamp = w_sum[TIME_W] ? '1 : w_sum[TIME_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        OP_INS_WAKE, OP_INS_DL: n_state = w_full ? ST_CLOSE : ST_INS_RD;
                        OP_REMOVE:              n_state = ST_RM_RD;
                        default:                n_state = ST_A_TOP;
                    endcase
                end
            end
            ST_INS_RD:  n_state = (r_i == '0) ? ST_INS_WR : ST_INS_CMP;
            ST_INS_CMP: n_state = (r_new.stamp < r_rdata.stamp) ? ST_INS_RD : ST_INS_WR;
            ST_INS_WR:  n_state = r_adv ? ST_A_TOP : ST_CLOSE;
            ST_POP1:    n_state = ST_POP2;
            ST_POP2:    n_state = ST_SD0;
            ST_SD0:     n_state = w_l_ok ? ST_SD1 : ST_SDW;
            ST_SD1:     n_state = w_r_ok ? ST_SD2 : ST_SDM;
            ST_SD2:     n_state = ST_SDM;
            ST_SDM:     n_state = (r_bi == r_i) ? ST_SDW : ST_SD0;
            ST_SDW:     n_state = r_adv ? ST_A_FIRE : ST_RM_RD;
            ST_RM_RD:   n_state = (r_i < r_cnt) ? ST_RM_CK : ST_CLOSE;
            ST_RM_CK:   n_state = (r_rdata.task_id == r_new.task_id) ? ST_RM_UP : ST_RM_RD;
            ST_RM_UP:   n_state = (r_j == '0) ? ST_POP1 : ST_RM_MV;
            ST_RM_MV:   n_state = ST_RM_UP;
            ST_A_TOP:   n_state = (r_cnt == '0) ? ST_CLOSE : ST_A_CK;
            ST_A_CK: begin
                if (!w_due || r_pops == POP_LIMIT) begin
                    n_state = ST_CLOSE;
                end else begin
                    n_state = ST_POP1;
                end
            end
            ST_A_FIRE: begin
                if (w_free) begin
                    n_state = r_top.deadline ? ST_INS_RD : ST_A_TOP;
                end
            end
            ST_CLOSE: begin
                if (w_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;     n_i = r_i;         n_j = r_j;       n_bi = r_bi;
        n_new = r_new;     n_last = r_last;   n_top = r_top;   n_best = r_best;
        n_tnow = r_tnow;   n_pops = r_pops;   n_woken = r_woken;
        n_status = r_status;                  n_adv = r_adv;
        n_ovalid = r_ovalid && i_stall;
        n_okind = r_okind; n_otask = r_otask; n_ostatus = r_ostatus;
        n_owoken = r_owoken;                  n_olast = r_olast;
        w_rd_en = 1'b0;    w_rd_addr = '0;
        w_wr_en = 1'b0;    w_wr_addr = r_i;   w_wr_data = r_last;
        w_per_we = 1'b0;   o_cmd_pop = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                w_per_we  = i_cmd_valid && (i_cmd.op == OP_INS_DL);
                n_new     = '{deadline: (i_cmd.op == OP_INS_DL), task_id: i_cmd.task_id,
                              stamp: i_cmd.time_value};
                n_tnow    = i_cmd.time_value;
                n_pops    = '0;
                n_woken   = 1'b0;
                n_adv     = (i_cmd.op == OP_ADVANCE);
                n_i       = (i_cmd.op == OP_REMOVE) ? '0 : r_cnt;
                n_status  = (w_full && (i_cmd.op == OP_INS_WAKE || i_cmd.op == OP_INS_DL))
                            ? STATUS_FULL : STATUS_OK;
            end
            ST_INS_RD: begin
                w_rd_en   = (r_i != '0);
                w_rd_addr = w_pi;
            end
            ST_INS_CMP: begin
                if (r_new.stamp < r_rdata.stamp) begin
                    w_wr_en   = 1'b1;
                    w_wr_data = r_rdata;
                    n_i       = w_pi;
                end
            end
            ST_INS_WR: begin
                w_wr_en   = 1'b1;
                w_wr_data = r_new;
                n_cnt     = r_cnt + 1'b1;
            end
            ST_POP1: begin
                n_cnt     = r_cnt - 1'b1;
                w_rd_en   = 1'b1;
                w_rd_addr = r_cnt - 1'b1;
            end
            ST_POP2: begin
                n_last = r_rdata;
                n_i    = '0;
            end
            ST_SD0: begin
                w_rd_en   = w_l_ok;
                w_rd_addr = w_l[IW-1:0];
            end
            ST_SD1: begin
                if (r_rdata.stamp < r_last.stamp) begin
                    n_best = r_rdata;
                    n_bi   = w_l[IW-1:0];
                end else begin
                    n_best = r_last;
                    n_bi   = r_i;
                end
                w_rd_en   = w_r_ok;
                w_rd_addr = w_r[IW-1:0];
            end
            ST_SD2: begin
                if (r_rdata.stamp < r_best.stamp) begin
                    n_best = r_rdata;
                    n_bi   = w_r[IW-1:0];
                end
            end
            ST_SDM: begin
                if (r_bi != r_i) begin
                    w_wr_en   = 1'b1;
                    w_wr_data = r_best;
                    n_i       = r_bi;
                end
            end
            ST_SDW: begin
                w_wr_en = 1'b1;
                n_i     = '0;
            end
            ST_RM_RD: begin
                w_rd_en   = (r_i < r_cnt);
                w_rd_addr = r_i;
            end
            ST_RM_CK: begin
                if (r_rdata.task_id == r_new.task_id) begin
                    n_j = r_i;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            ST_RM_UP: begin
                w_rd_en   = (r_j != '0);
                w_rd_addr = w_pj;
            end
            ST_RM_MV: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_j;
                w_wr_data = r_rdata;
                n_j       = w_pj;
            end
            ST_A_TOP: begin
                w_rd_en   = (r_cnt != '0);
                w_rd_addr = '0;
            end
            ST_A_CK: begin
                if (w_due) begin
                    if (r_pops == POP_LIMIT) begin
                        n_status = STATUS_LIMIT;
                    end else begin
                        n_top = r_rdata;
                    end
                end
            end
            ST_A_FIRE: begin
                if (w_free) begin
                    n_ovalid  = 1'b1;
                    n_okind   = r_top.deadline ? KIND_DEADLINE : KIND_WAKE;
                    n_otask   = r_top.task_id;
                    n_ostatus = STATUS_OK;
                    n_owoken  = 1'b0;
                    n_olast   = 1'b0;
                    n_pops    = r_pops + 1'b1;
                    n_woken   = r_woken || !r_top.deadline;
                    n_new     = '{deadline: 1'b1, task_id: r_top.task_id,
                                  stamp: w_next_stamp};
                    n_i       = r_cnt;
                end
            end
            ST_CLOSE: begin
                if (w_free) begin
                    n_ovalid  = 1'b1;
                    n_okind   = KIND_CLOSE;
                    n_otask   = '0;
                    n_ostatus = r_status;
                    n_owoken  = r_woken;
                    n_olast   = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
        if (w_per_we) begin
            r_period[i_cmd.task_id] <= i_cmd.period;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;       r_j <= n_j;         r_bi <= n_bi;
        r_new <= n_new;   r_last <= n_last;   r_top <= n_top;   r_best <= n_best;
        r_tnow <= n_tnow; r_pops <= n_pops;   r_woken <= n_woken;
        r_status <= n_status;                 r_adv <= n_adv;
        r_okind <= n_okind;                   r_otask <= n_otask;
        r_ostatus <= n_ostatus;               r_owoken <= n_owoken;
        r_olast <= n_olast;
    end

    assign o_valid      = r_ovalid;
    assign o_kind       = r_okind;
    assign o_fired_task = r_otask;
    assign o_status     = r_ostatus;
    assign o_any_woken  = r_owoken;
    assign o_last       = r_olast;
    assign o_count      = r_cnt;

endmodule

// ===== rtl/timer_event_heap_queue_core.sv =====
// ----------------------------------------------------------------------------
// Timer event heap queue core
// Binary min-heap of wake and deadline events with a queued command front.
// ----------------------------------------------------------------------------
//  channel   valid     stall     payload
//  input     i_valid   o_stall   i_func i_task_id i_time_value i_period
//  output    o_valid   i_stall   o_kind o_fired_task o_status o_any_woken o_last
//
// Each heap step uses one port of the event memory per cycle, so inserts
// and pops walk the heap one level at a time and a remove adds a linear
// search. A two-entry command queue lets input transfers continue while
// the heap engine works. Reset is synchronous and empties the heap; an
// output stall holds the engine until the transfer.
module timer_event_heap_queue_core #(
    parameter int DEPTH = tehq_pkg::DEPTH_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_func,
    input  logic [tehq_pkg::TASK_W-1:0] i_task_id,
    input  logic [tehq_pkg::TIME_W-1:0] i_time_value,
    input  logic [tehq_pkg::TIME_W-1:0] i_period,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_kind,
    output logic [tehq_pkg::TASK_W-1:0] o_fired_task,
    output logic [1:0]                  o_status,
    output logic                        o_any_woken,
    output logic                        o_last
);
    import tehq_pkg::*;

    logic                 w_cmd_valid;
    t_cmd                 w_cmd;
    logic                 w_cmd_pop;
    logic [$clog2(DEPTH)-1:0] w_count;

    tehq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_task_id    (i_task_id),
        .i_time_value (i_time_value),
        .i_period     (i_period),
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd        (w_cmd),
        .i_cmd_pop    (w_cmd_pop)
    );

    tehq_back #(.DEPTH(DEPTH)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_cmd_valid),
        .i_cmd        (w_cmd),
        .o_cmd_pop    (w_cmd_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_fired_task (o_fired_task),
        .o_status     (o_status),
        .o_any_woken  (o_any_woken),
        .o_last       (o_last),
        .o_count      (w_count)
    );

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= ($clog2(DEPTH))'(DEPTH - 1))
        else $error("heap count exceeds capacity");

    a_last_close : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_kind == KIND_CLOSE)
        else $error("last flag on a fired event");

    a_fired_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_CLOSE |-> o_status == STATUS_OK && !o_any_woken && !o_last)
        else $error("fired event carries status bits");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timer event heap queue testbench
// Drives inserts, removes and advances into the core and checks every result
// against a behavioural min-heap kept in a scoreboard class.
// ----------------------------------------------------------------------------
module tb_top;
    import tehq_pkg::*;

    typedef struct {
        logic [1:0] kind;
        logic [3:0] fired;
        logic [1:0] status;
        logic       woken;
        logic       last;
    } t_fired_result;

    class event_scoreboard;
        logic [36:0]     heap_q [16];
        int unsigned     count;
        logic [31:0]     period_of [16];
        t_fired_result   pending [$];
        int              errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function void swap_entries(int a, int b);
            logic [36:0] t;
            t         = heap_q[a];
            heap_q[a] = heap_q[b];
            heap_q[b] = t;
        endfunction

        function void sift_down(int i);
            int best;
            int l;
            int r;
            forever begin
                best = i;
                l    = 2 * i + 1;
                r    = 2 * i + 2;
                if (l < count && heap_q[l][31:0] < heap_q[best][31:0]) best = l;
                if (r < count && heap_q[r][31:0] < heap_q[best][31:0]) best = r;
                if (best == i) break;
                swap_entries(i, best);
                i = best;
            end
        endfunction

        function bit heap_add(logic dl, logic [3:0] id, logic [31:0] stamp);
            int i;
            if (count + 1 >= 16) return 0;
            heap_q[count] = {dl, id, stamp};
            count++;
            i = count - 1;
            while (i > 0 && heap_q[i][31:0] < heap_q[(i - 1) / 2][31:0]) begin
                swap_entries(i, (i - 1) / 2);
                i = (i - 1) / 2;
            end
            return 1;
        endfunction

        function logic [36:0] heap_take();
            logic [36:0] top;
            top       = heap_q[0];
            count--;
            heap_q[0] = heap_q[count];
            sift_down(0);
            return top;
        endfunction

        function void push(logic [1:0] k, logic [3:0] id, logic [1:0] st, logic w,
                           logic l);
            t_fired_result r;
            r.kind   = k;
            r.fired  = id;
            r.status = st;
            r.woken  = w;
            r.last   = l;
            pending.push_back(r);
        endfunction

        function void note_input(t_op op, logic [3:0] id, logic [31:0] tv,
                                 logic [31:0] per);
            int          idx;
            int          pops;
            bit          found;
            bit          woken;
            logic [1:0]  st;
            logic [36:0] e;
            logic [32:0] sum;
            case (op)
                OP_INS_WAKE, OP_INS_DL: begin
                    if (op == OP_INS_DL) period_of[id] = per;
                    push(KIND_CLOSE, 0, heap_add(op == OP_INS_DL, id, tv) ? STATUS_OK
                         : STATUS_FULL, 0, 1);
                end
                OP_REMOVE: begin
                    forever begin
                        found = 0;
                        for (int i = 0; i < count; i++) begin
                            if (heap_q[i][35:32] == id) begin
                                idx   = i;
                                found = 1;
                                break;
                            end
                        end
                        if (!found) break;
                        while (idx > 0) begin
                            swap_entries(idx, (idx - 1) / 2);
                            idx = (idx - 1) / 2;
                        end
                        void'(heap_take());
                    end
                    push(KIND_CLOSE, 0, STATUS_OK, 0, 1);
                end
                default: begin
                    pops  = 0;
                    woken = 0;
                    st    = STATUS_OK;
                    while (count > 0 && heap_q[0][31:0] <= tv) begin
                        if (pops == POP_LIMIT) begin
                            st = STATUS_LIMIT;
                            break;
                        end
                        e = heap_take();
                        if (e[36]) begin
                            sum = e[31:0] + period_of[e[35:32]];
                            void'(heap_add(1, e[35:32], sum[32] ? 32'hFFFF_FFFF : sum[31:0]));
                            push(KIND_DEADLINE, e[35:32], STATUS_OK, 0, 0);
                        end else begin
                            woken = 1;
                            push(KIND_WAKE, e[35:32], STATUS_OK, 0, 0);
                        end
                        pops++;
                    end
                    push(KIND_CLOSE, 0, st, woken, 1);
                end
            endcase
        endfunction

        function void check_result(t_fired_result got);
            t_fired_result exp;
            if (pending.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.kind !== exp.kind) begin
                $error("kind: expected %0d, got %0d", exp.kind, got.kind);
                errors++;
            end
            if (got.fired !== exp.fired) begin
                $error("fired_task: expected %0d, got %0d", exp.fired, got.fired);
                errors++;
            end
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.woken !== exp.woken) begin
                $error("any_woken: expected %0d, got %0d", exp.woken, got.woken);
                errors++;
            end
            if (got.last !== exp.last) begin
                $error("last: expected %0d, got %0d", exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [1:0]  i_func = 0;
    logic [3:0]  i_task_id = 0;
    logic [31:0] i_time_value = 0;
    logic [31:0] i_period = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [1:0]  o_kind;
    logic [3:0]  o_fired_task;
    logic [1:0]  o_status;
    logic        o_any_woken;
    logic        o_last;

    event_scoreboard sb = new();
    int              send_idle_pct;
    int              recv_idle_pct;
    int              quiet_cycles = 0;
    logic [31:0]     now_us;

    timer_event_heap_queue_core u_top (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        t_fired_result r;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                r.kind   = o_kind;
                r.fired  = o_fired_task;
                r.status = o_status;
                r.woken  = o_any_woken;
                r.last   = o_last;
                sb.check_result(r);
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles > 20000) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_cmd(t_op op, logic [3:0] id, logic [31:0] tv, logic [31:0] per);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid      <= 1;
        i_func       <= op;
        i_task_id    <= id;
        i_time_value <= tv;
        i_period     <= per;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(op, id, tv, per);
    endtask

    task automatic random_cmd();
        int sel;
        sel = $urandom_range(99);
        now_us = now_us + $urandom_range(400);
        if (sel < 35)
            send_cmd(OP_INS_WAKE, 4'($urandom_range(15)), now_us + $urandom_range(1500),
                     0);
        else if (sel < 60)
            send_cmd(OP_INS_DL, 4'($urandom_range(15)), now_us + $urandom_range(1500),
                     $urandom_range(1, 600));
        else if (sel < 70)
            send_cmd(OP_REMOVE, 4'($urandom_range(15)), $urandom, $urandom);
        else if (sel < 95)
            send_cmd(OP_ADVANCE, 4'($urandom_range(15)), now_us, $urandom);
        else
            send_cmd(t_op'($urandom_range(3)), 4'($urandom_range(15)), $urandom,
                     $urandom_range(1, 32'hFFFF_FFFF));
    endtask

    initial begin
        send_idle_pct = 7;
        recv_idle_pct = 47;
        now_us        = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extremes, full queue, deadline saturation, pop limit, remove.
        send_cmd(OP_ADVANCE, 0, 0, 0);
        send_cmd(OP_INS_DL, 15, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
        send_cmd(OP_INS_WAKE, 0, 32'hFFFF_FFFF, 0);
        send_cmd(OP_ADVANCE, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(OP_REMOVE, 15, 0, 0);
        send_cmd(OP_REMOVE, 7, 0, 0);
        for (int i = 0; i < 16; i++) send_cmd(OP_INS_WAKE, 4'(i), 100 - i, 1);
        send_cmd(OP_INS_DL, 9, 5, 1);
        send_cmd(OP_ADVANCE, 0, 50, 0);
        send_cmd(OP_REMOVE, 2, 0, 0);
        send_cmd(OP_ADVANCE, 0, 1000, 0);
        send_cmd(OP_INS_DL, 4, 0, 1);
        send_cmd(OP_INS_DL, 5, 0, 1);
        send_cmd(OP_ADVANCE, 0, 200, 0);
        send_cmd(OP_REMOVE, 4, 0, 0);
        send_cmd(OP_REMOVE, 5, 0, 0);
        now_us = 300;

        for (int n = 0; n < 260; n++) begin
            if (n == 90)  begin send_idle_pct = 47; recv_idle_pct = 7; end
            if (n == 180) begin send_idle_pct = 0;  recv_idle_pct = 0; end
            random_cmd();
        end
        i_valid <= 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
